[rtl/itp_pkg.sv]
// Shared types, character codes and decode functions for the infix to postfix converter.
package itp_pkg;

  // Character codes
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_end;
  } itp_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_char_valid;
    logic       out_last;
    logic       out_error;
  } itp_out_t;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_ALNUM,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPER
  } itp_class_e;

  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_TOP,
    SEL_MARK
  } itp_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_OPEN,
    ST_CLOSE,
    ST_OPER,
    ST_FLUSH
  } itp_state_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     push;
    logic     pop;
    logic     set_err;
    logic     emit;
    itp_sel_e emit_sel;
    logic     last;
  } itp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    itp_class_e in_class;
    logic       in_end;
    logic       end_item;
    logic       empty;
    logic       full;
    logic       top_lparen;
    logic       top_pops;
    logic       open_zero;
    logic       np_none;
    logic       np_one;
    logic       out_free;
  } itp_sts_t;

  // Operator precedence; 0 for anything that is not an operator
  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    p = 2'd0;
    if (ch == CH_CARET) p = 2'd3;
    else if (ch == CH_STAR || ch == CH_SLASH) p = 2'd2;
    else if (ch == CH_PLUS || ch == CH_MINUS) p = 2'd1;
    return p;
  endfunction

  function automatic itp_class_e class_of(input logic [7:0] ch);
    itp_class_e c;
    c = CLS_IGNORE;
    if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
        (ch >= 8'h30 && ch <= 8'h39)) c = CLS_ALNUM;
    else if (ch == CH_LPAREN) c = CLS_LPAREN;
    else if (ch == CH_RPAREN) c = CLS_RPAREN;
    else if (prec_of(ch) != 2'd0) c = CLS_OPER;
    return c;
  endfunction

endpackage

[rtl/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix to postfix converter.
//
// Converts an infix expression, one ASCII character per input transaction, to
// postfix form, one character per output transaction. Letters and digits go
// straight out; '(' and the operators ^ * / + - are held on an operator stack
// of STACK_DEPTH entries (^ binds tightest, + - loosest, all left-associative);
// ')' unwinds to its '('. An input with in_end set flushes the stack and the
// final output transaction of the expression carries out_last; if the
// end item emitted nothing, a single empty end marker (out_char_valid low)
// is sent. Other characters are ignored. Stack overflow or an unmatched ')'
// raise out_error, which stays set on every later output until reset.
// Timing: one item is worked at a time. It is accepted in the idle state, then
// passes through its work state, which pops operators one at a time and waits
// while the output side stalls; an end item then passes through the flush
// state, which drains the stack. An ignored character without in_end has no
// work state. The next item is accepted once the controller is idle again.
// The pop rate of one per cycle, while the output side does not stall, is set
// by the stack: the top entry lives in a register and the entry beneath it is
// read ahead from a single RAM with registered read. The stack needs no
// clearing pass after reset. A finished output waits in an output register, so
// the input side goes on taking items while it waits to be taken; only an item
// with a transaction of its own to send stalls until the register is free.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itp_pkg::itp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output itp_pkg::itp_out_t out_data_o
);
  import itp_pkg::*;

  itp_cmd_t cmd;
  itp_sts_t sts;

  // sequencing
  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack, item and output registers
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // an empty marker is only ever the end of an expression
  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_char_valid |-> out_data_o.out_last)
    else $error("empty marker without out_last");

  // never push onto a full stack
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.full)
    else $error("push on full stack");

  // never overwrite an output transaction that has not been taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("output register overrun");

  // push and pop are exclusive, and nothing pops an empty stack
  a_stack_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !cmd.push && !sts.empty)
    else $error("illegal stack operation");
`endif

endmodule

[rtl/itp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/itp_datapath.sv]
// Datapath: item registers, operator stack (top register plus RAM), output register.
module itp_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itp_pkg::itp_cmd_t cmd_i,
  output itp_pkg::itp_sts_t sts_o,
  input  itp_pkg::itp_in_t  in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output itp_pkg::itp_out_t out_data_o
);
  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    char_q;
  logic          end_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] open_q, open_d;
  logic          error_q, error_d;
  logic [7:0]    top_q, top_d;
  logic [7:0]    byp_q;
  logic          byp_sel_q;
  logic [7:0]    below;
  logic [7:0]    ram_rdata;
  logic [CW-1:0] cnt_m1, cnt_d_m2, np_cnt;
  logic [AW-1:0] raddr;
  logic          out_valid_q, out_valid_d;
  itp_out_t      out_q, out_d;

  // entry under the top: RAM data, or the value just written on a push
  assign below = byp_sel_q ? byp_q : ram_rdata;

  always_comb begin
    count_d = count_q;
    open_d  = open_q;
    top_d   = top_q;
    error_d = error_q | cmd_i.set_err;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      top_d   = char_q;
      if (char_q == CH_LPAREN) open_d = open_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      top_d   = below;
      if (top_q == CH_LPAREN) open_d = open_q - CW'(1);
    end
  end

  assign cnt_m1   = count_q - CW'(1);
  assign cnt_d_m2 = count_d - CW'(2);
  assign raddr    = (count_d >= CW'(2)) ? cnt_d_m2[AW-1:0] : '0;

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && (count_q != '0)),
    .waddr_i (cnt_m1[AW-1:0]),
    .wdata_i (top_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      open_q      <= '0;
      error_q     <= 1'b0;
      byp_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      open_q      <= open_d;
      error_q     <= error_d;
      byp_sel_q   <= cmd_i.push;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.push) begin
      byp_q <= top_q;
    end
    if (cmd_i.load) begin
      char_q <= in_data_i.in_char;
      end_q  <= in_data_i.in_end;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  // output register
  always_comb begin
    out_d.out_char_valid = (cmd_i.emit_sel != SEL_MARK);
    out_d.out_last       = cmd_i.last;
    out_d.out_error      = error_d;
    unique case (cmd_i.emit_sel)
      SEL_CHAR: out_d.out_char = char_q;
      SEL_TOP:  out_d.out_char = top_q;
      default:  out_d.out_char = CH_NUL;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status
  assign np_cnt = count_q - open_q;

  always_comb begin
    sts_o.in_class   = class_of(in_data_i.in_char);
    sts_o.in_end     = in_data_i.in_end;
    sts_o.end_item   = end_q;
    sts_o.empty      = (count_q == '0);
    sts_o.full       = (count_q == CW'(STACK_DEPTH));
    sts_o.top_lparen = (top_q == CH_LPAREN);
    sts_o.top_pops   = (count_q != '0) && (prec_of(top_q) >= prec_of(char_q));
    sts_o.open_zero  = (open_q == '0);
    sts_o.np_none    = (np_cnt == '0);
    sts_o.np_one     = (np_cnt == CW'(1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

[rtl/itp_ctrl.sv]
// Controller: state machine sequencing pushes, pops and emissions for one item.
module itp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itp_pkg::itp_sts_t sts_i,
  output itp_pkg::itp_cmd_t cmd_o
);
  import itp_pkg::*;

  itp_state_e state_q, state_d;
  logic       emitted_q, emitted_d;
  itp_state_e done_st;

  assign in_ready_o = (state_q == ST_IDLE);
  assign done_st    = sts_i.end_item ? ST_FLUSH : ST_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.in_class)
            CLS_ALNUM:  state_d = ST_CHAR;
            CLS_LPAREN: state_d = ST_OPEN;
            CLS_RPAREN: state_d = ST_CLOSE;
            CLS_OPER:   state_d = ST_OPER;
            default:    state_d = sts_i.in_end ? ST_FLUSH : ST_IDLE;
          endcase
        end
      end
      ST_CHAR: begin
        if (sts_i.out_free) state_d = done_st;
      end
      ST_OPEN: state_d = done_st;
      ST_CLOSE: begin
        if (sts_i.empty || sts_i.top_lparen) state_d = done_st;
      end
      ST_OPER: begin
        if (!sts_i.top_pops) state_d = done_st;
      end
      ST_FLUSH: begin
        if (sts_i.empty && (emitted_q || sts_i.out_free)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '{load: 1'b0, push: 1'b0, pop: 1'b0, set_err: 1'b0, emit: 1'b0,
              emit_sel: SEL_TOP, last: 1'b0};
    unique case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_CHAR: begin
        cmd_o.emit_sel = SEL_CHAR;
        cmd_o.emit     = sts_i.out_free;
        cmd_o.last     = sts_i.end_item && sts_i.np_none;
      end
      ST_OPEN: begin
        cmd_o.set_err = sts_i.full;
        cmd_o.push    = !sts_i.full;
      end
      ST_CLOSE: begin
        cmd_o.set_err = sts_i.open_zero;
        if (!sts_i.empty) begin
          if (sts_i.top_lparen) begin
            cmd_o.pop = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.last = sts_i.end_item && sts_i.np_one;
          end
        end
      end
      ST_OPER: begin
        if (sts_i.top_pops) begin
          cmd_o.pop  = sts_i.out_free;
          cmd_o.emit = sts_i.out_free;
        end else begin
          cmd_o.set_err = sts_i.full;
          cmd_o.push    = !sts_i.full;
        end
      end
      ST_FLUSH: begin
        if (sts_i.empty) begin
          // nothing emitted for this item: empty end marker
          if (!emitted_q && sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_MARK;
            cmd_o.last     = 1'b1;
          end
        end else if (sts_i.top_lparen) begin
          cmd_o.pop = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.pop  = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.np_one;
        end
      end
      default: ;
    endcase
  end

  assign emitted_d = cmd_o.load ? 1'b0 : (emitted_q | cmd_o.emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

[bench/tb.sv]
// Self-checking testbench for the infix to postfix converter.
`timescale 1ns / 100ps

module tb;
  import itp_pkg::*;

  localparam int          DEPTH       = 16;
  localparam int          CYCLE_LIMIT = 500000;
  // Base codes for the pass-through character ranges
  localparam logic [7:0]  CH_DIGIT0   = 8'h30;  // '0'
  localparam logic [7:0]  CH_UPPER_A  = 8'h41;  // 'A'
  localparam logic [7:0]  CH_LOWER_A  = 8'h61;  // 'a'
  localparam logic [7:0]  CH_LOWER_Q  = 8'h71;  // 'q'

  // Mirror of the converter: own operator stack and sticky error, plus the
  // queue of postfix transactions still owed by the block.
  class postfix_scoreboard;
    logic [7:0]  op_stack [DEPTH];
    int unsigned stack_count;
    bit          error_seen;
    itp_out_t    pending_postfix [$];
    int          failures;

    function new();
      stack_count = 0;
      error_seen  = 1'b0;
      failures    = 0;
    endfunction

    static function itp_class_e kind_of(logic [7:0] ch);
      if ((ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd25) ||
          (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd25) ||
          (ch >= CH_DIGIT0 && ch <= CH_DIGIT0 + 8'd9)) return CLS_ALNUM;
      if (ch == CH_LPAREN) return CLS_LPAREN;
      if (ch == CH_RPAREN) return CLS_RPAREN;
      if (rank_of(ch) > 0) return CLS_OPER;
      return CLS_IGNORE;
    endfunction

    static function int rank_of(logic [7:0] ch);
      if (ch == CH_CARET) return 3;
      if (ch == CH_STAR || ch == CH_SLASH) return 2;
      if (ch == CH_PLUS || ch == CH_MINUS) return 1;
      return 0;
    endfunction

    static function itp_out_t char_result(logic [7:0] ch);
      itp_out_t r;
      r.out_char       = ch;
      r.out_char_valid = 1'b1;
      r.out_last       = 1'b0;
      r.out_error      = 1'b0;
      return r;
    endfunction

    function void push_entry(logic [7:0] ch);
      // full stack: the entry is dropped and the error sticks
      if (stack_count >= DEPTH) error_seen = 1'b1;
      else begin
        op_stack[stack_count] = ch;
        stack_count++;
      end
    endfunction

    // Work out every postfix transaction one accepted input causes.
    function void note_item(itp_in_t item);
      itp_out_t   step_out [$];
      itp_out_t   marker;
      logic [7:0] top;
      bit         matched;
      case (kind_of(item.in_char))
        CLS_ALNUM: begin
          step_out.push_back(char_result(item.in_char));
        end
        CLS_LPAREN: begin
          push_entry(item.in_char);
        end
        CLS_RPAREN: begin
          matched = 1'b0;
          while (stack_count > 0 && !matched) begin
            top = op_stack[stack_count - 1];
            stack_count--;
            if (top == CH_LPAREN) matched = 1'b1;
            else step_out.push_back(char_result(top));
          end
          // no '(' below: everything popped, error raised
          if (!matched) error_seen = 1'b1;
        end
        CLS_OPER: begin
          while (stack_count > 0 &&
                 rank_of(op_stack[stack_count - 1]) >= rank_of(item.in_char)) begin
            step_out.push_back(char_result(op_stack[stack_count - 1]));
            stack_count--;
          end
          push_entry(item.in_char);
        end
        default: ;
      endcase
      if (item.in_end) begin
        // flush; left-over '(' entries vanish silently
        while (stack_count > 0) begin
          top = op_stack[stack_count - 1];
          stack_count--;
          if (top != CH_LPAREN) step_out.push_back(char_result(top));
        end
        if (step_out.size() == 0) begin
          marker = char_result(CH_NUL);
          marker.out_char_valid = 1'b0;
          step_out.push_back(marker);
        end
        step_out[step_out.size() - 1].out_last = 1'b1;
      end
      // error flag reflects the state after the whole step
      foreach (step_out[i]) begin
        step_out[i].out_error = error_seen;
        pending_postfix.push_back(step_out[i]);
      end
    endfunction

    function void check_result(itp_out_t got);
      itp_out_t want;
      if (pending_postfix.size() == 0) begin
        $error("unexpected output transaction: out_char %h", got.out_char);
        failures++;
        return;
      end
      want = pending_postfix.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
        failures++;
      end
      if (got.out_char_valid !== want.out_char_valid) begin
        $error("out_char_valid: expected %b, actual %b",
               want.out_char_valid, got.out_char_valid);
        failures++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
        failures++;
      end
      if (got.out_error !== want.out_error) begin
        $error("out_error: expected %b, actual %b", want.out_error, got.out_error);
        failures++;
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  itp_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  itp_out_t out_data_o;

  postfix_scoreboard sb = new();
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          items_sent  = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  expr_chars [$];

  infix_to_postfix_converter #(
    .STACK_DEPTH (DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check each accepted transaction, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One input transaction; valid stays up across back-to-back items.
  task automatic send_item(input logic [7:0] ch, input logic last_char);
    itp_in_t item;
    item.in_char = ch;
    item.in_end  = last_char;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(item);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_item(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  function automatic logic [7:0] rand_alnum();
    int k;
    k = $urandom_range(0, 61);
    if (k < 10) return CH_DIGIT0 + 8'(k);
    if (k < 36) return CH_UPPER_A + 8'(k - 10);
    return CH_LOWER_A + 8'(k - 36);
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // Clean noise never touches the parentheses, so it cannot raise the error.
  function automatic logic [7:0] rand_noise(input bit broken);
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (!broken && (ch == CH_LPAREN || ch == CH_RPAREN)) ch = ~ch;
    return ch;
  endfunction

  // Random infix expression. Clean ones keep paren depth to 3, so the stack
  // (at most three operators per level) never overflows. Broken ones nest
  // deeper, add stray ')' and operators, and sometimes a long run of '('.
  function automatic void build_expr(input bit broken);
    int terms, depth, max_depth, k;
    expr_chars.delete();
    max_depth = broken ? 9 : 3;
    terms     = $urandom_range(1, 6);
    depth     = 0;
    if (broken && $urandom_range(0, 7) == 0) begin
      k = $urandom_range(12, 18);
      repeat (k) expr_chars.push_back(CH_LPAREN);
    end
    for (int t = 0; t < terms; t++) begin
      k = $urandom_range(0, 2);
      while (k > 0 && depth < max_depth) begin
        expr_chars.push_back(CH_LPAREN);
        depth++;
        k--;
      end
      if ($urandom_range(0, 7) == 0) expr_chars.push_back(rand_noise(broken));
      expr_chars.push_back(rand_alnum());
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, depth);
        repeat (k) expr_chars.push_back(CH_RPAREN);
        depth -= k;
      end
      if (broken && $urandom_range(0, 5) == 0) expr_chars.push_back(CH_RPAREN);
      if (broken && $urandom_range(0, 5) == 0) expr_chars.push_back(rand_oper());
      if (t < terms - 1) expr_chars.push_back(rand_oper());
    end
    if ($urandom_range(0, 4) != 0) repeat (depth) expr_chars.push_back(CH_RPAREN);
    // sometimes the end flag rides on an ignored or stray character
    if ($urandom_range(0, 7) == 0) expr_chars.push_back(rand_noise(broken));
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni      <= 1'b1;
    tx_idle_pct <= 13;
    rx_idle_pct <= 66;

    // Directed: precedence, left associativity, field extremes, ignored
    // characters, '(' left open at the end, end with nothing to emit.
    send_text("a+b*c");
    send_text("(Z-0)^9/z");
    send_item(CH_NUL, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("A-(");
    send_item(8'hFF, 1'b1);
    send_text("a-b+c");

    while (items_sent < 137) begin
      build_expr(1'b0);
      send_expr();
    end

    tx_idle_pct <= 66;
    rx_idle_pct <= 13;
    while (items_sent < 274) begin
      build_expr(1'b0);
      send_expr();
    end

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    while (items_sent < 330) begin
      build_expr(1'b0);
      send_expr();
    end

    // Error cases last, as the flag is sticky: unmatched ')', then a full
    // stack meeting an operator and another '('.
    send_text("a+b)");
    repeat (DEPTH) send_item(CH_LPAREN, 1'b0);
    send_item(CH_PLUS, 1'b0);
    send_item(CH_LPAREN, 1'b0);
    send_item(CH_LOWER_Q, 1'b1);
    while (items_sent < 410) begin
      build_expr($urandom_range(0, 2) != 0);
      send_expr();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_postfix.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_postfix.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
